// ===== rtl/snr_pkg.sv =====
// ----------------------------------------------------------------------------
// snr_pkg: shared types and constants of the spiking neuron RK4 step block
// Fixed-point constants, operand type of the shared multiplier, CSR indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package snr_pkg;
   typedef logic signed [31:0] q_type;

   // Q15.16 constants
   localparam logic signed [31:0] K004    = 32'sd2621;
   localparam logic signed [31:0] KSixth  = 32'sd10923;
   localparam logic signed [34:0] KHalf   = 35'sd32768;
   localparam logic signed [35:0] K140    = 36'sd9175040;
   localparam logic signed [35:0] VPeak   = 36'sd1966080;

   // CSR indexes
   localparam logic [2:0] CsrRate  = 3'd0;
   localparam logic [2:0] CsrSens  = 3'd1;
   localparam logic [2:0] CsrReset = 3'd2;
   localparam logic [2:0] CsrJump  = 3'd3;
   localparam logic [2:0] CsrStep  = 3'd4;
   localparam logic [2:0] CsrRec   = 3'd5;

   // operands of the shared multiplier: signed 32 x signed 35
   // (op_b is wider so the weighted RK sum fits)
   typedef struct packed {
      logic signed [31:0] op_a;
      logic signed [34:0] op_b;
   } mul_req_type;

   // saturate a wide signed value to 32 bits
   function automatic q_type sat36(input logic signed [35:0] x);
      if (x > 36'sd2147483647) return 32'sh7FFFFFFF;
      else if (x < -36'sd2147483648) return 32'sh80000000;
      else return x[31:0];
   endfunction
endpackage
`default_nettype wire

// ===== rtl/snr_if.sv =====
// ----------------------------------------------------------------------------
// snr_if: valid/ready channel interfaces of the neuron block
// Request, response and CSR write channels.
// ----------------------------------------------------------------------------
`default_nettype none
interface snr_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [31:0] input_current;
   logic [31:0] sim_time;
   logic [31:0] initial_potential;
   logic [31:0] initial_recovery;
   modport source(output valid, mode, input_current, sim_time, initial_potential,
      initial_recovery, input ready);
   modport sink(input valid, mode, input_current, sim_time, initial_potential,
      initial_recovery, output ready);
endinterface

interface snr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] potential_out;
   logic [31:0] recovery_out;
   logic        spiked;
   logic        spike_recorded;
   logic        not_loaded_error;
   modport source(output valid, potential_out, recovery_out, spiked, spike_recorded,
      not_loaded_error, input ready);
   modport sink(input valid, potential_out, recovery_out, spiked, spike_recorded,
      not_loaded_error, output ready);
endinterface

interface snr_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/snr_qmul.sv =====
// ----------------------------------------------------------------------------
// snr_qmul: shared Q15.16 multiplier
// One registered product per cycle, rounded half up and saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module snr_qmul (
   input  wire logic                 clock,
   input  wire snr_pkg::mul_req_type mul_req,
   output snr_pkg::q_type            product
);
   logic signed [66:0] full;
   logic signed [50:0] shifted;
   snr_pkg::q_type     prod_ff, prod_in;

   // rounding: adding one half then an arithmetic shift (floor) rounds half up
   always_comb begin
      full    = mul_req.op_a * mul_req.op_b + 67'sd32768;
      shifted = full[66:16];
      if (shifted > 51'sd2147483647)       prod_in = 32'sh7FFFFFFF;
      else if (shifted < -51'sd2147483648) prod_in = 32'sh80000000;
      else                                  prod_in = shifted[31:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;
endmodule
`default_nettype wire

// ===== rtl/spiking_neuron_rk4_step.sv =====
// ----------------------------------------------------------------------------
// spiking_neuron_rk4_step: one Izhikevich neuron, one RK4 step per request
// Sequencer around a single shared Q15.16 multiplier.
// ----------------------------------------------------------------------------
// Usage:
//  req channel: mode 1 loads potential and recovery; mode 0 integrates one
//  step with input_current; a spike at sim_time >= record_after is recorded.
//  rsp channel: one response per request with the new state and flags.
//  csr channel: writes parameters a, b, c, d, h and record_after; accepted
//  any time, meant to be written while idle.
//  Sequence: a load or an early step goes from acceptance through DONE to
//  RESP; an integration step runs 4 stages of 6 multiplies, 2 halvings in
//  each of the first two stages and 2 final multiplies: 30 multiplier
//  passes, each an ISSUE and a WAIT state, then DONE and RESP. The single
//  multiplier, fed back through its output register, sets this sequence.
//  A new request is taken only after the response, once the block is back
//  in idle.
//  One request is in flight at a time: req ready is low from acceptance until
//  the response is taken, so a stalled receiver holds the block.
//  Reset clears the state to zero, marks the neuron unloaded and restores the
//  parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none
module spiking_neuron_rk4_step (
   input wire logic clock,
   input wire logic reset,
   snr_req_if.sink   req,
   snr_rsp_if.source rsp,
   snr_csr_if.sink   csr
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_ISSUE, ST_WAIT, ST_DONE, ST_RESP
   } state_type;

   // ops of one stage, then the two final ops
   typedef enum logic [3:0] {
      OP_SQ, OP_T, OP_BV, OP_FU, OP_K, OP_L, OP_HK, OP_HL, OP_SV, OP_SU
   } op_type;

   state_type state_ff;
   op_type    op_ff;
   logic [1:0] stage_ff;

   // parameters
   logic [16:0] rate_ff, sens_ff, step_ff;
   logic signed [23:0] creset_ff;
   logic [20:0] jump_ff;
   logic [31:0] rec_after_ff;

   // neuron state and working registers
   snr_pkg::q_type v_ff, u_ff, vs_ff, us_ff, cur_ff;
   snr_pkg::q_type sq_ff, bv_ff, fv_ff, fu_ff, k_ff;
   logic signed [35:0] sv_ff, su_ff;
   logic loaded_ff;
   logic [31:0] time_ff;

   // response registers
   snr_pkg::q_type out_v_ff, out_u_ff;
   logic spk_ff, rec_ff, err_ff;

   snr_pkg::mul_req_type mreq;
   snr_pkg::q_type       prod;
   snr_qmul u_mul (.clock(clock), .mul_req(mreq), .product(prod));

   logic signed [35:0] fv_sum, diff, nv_sum, nu_sum;
   snr_pkg::q_type sat_fv, sat_diff, stage_v, stage_u, fin_v, fin_u;

   // operand select for the shared multiplier
   always_comb begin
      mreq.op_a = '0;
      mreq.op_b = '0;
      unique case (op_ff)
         OP_SQ: begin mreq.op_a = vs_ff; mreq.op_b = 35'(vs_ff); end
         OP_T:  begin mreq.op_a = snr_pkg::K004; mreq.op_b = 35'(sq_ff); end
         OP_BV: begin
            mreq.op_a = 32'($signed({1'b0, sens_ff}));
            mreq.op_b = 35'(vs_ff);
         end
         OP_FU: begin
            mreq.op_a = 32'($signed({1'b0, rate_ff}));
            mreq.op_b = 35'(sat_diff);
         end
         OP_K:  begin
            mreq.op_a = 32'($signed({1'b0, step_ff}));
            mreq.op_b = 35'(fv_ff);
         end
         OP_L:  begin
            mreq.op_a = 32'($signed({1'b0, step_ff}));
            mreq.op_b = 35'(fu_ff);
         end
         OP_HK: begin mreq.op_a = k_ff; mreq.op_b = snr_pkg::KHalf; end
         OP_HL: begin mreq.op_a = prod; mreq.op_b = snr_pkg::KHalf; end
         OP_SV: begin mreq.op_a = snr_pkg::KSixth; mreq.op_b = 35'(sv_ff); end
         OP_SU: begin mreq.op_a = snr_pkg::KSixth; mreq.op_b = 35'(su_ff); end
         default: begin mreq.op_a = '0; mreq.op_b = '0; end
      endcase
   end

   // sums around the multiplier
   always_comb begin
      fv_sum  = 36'(prod) + 36'(vs_ff) * 36'sd5 + snr_pkg::K140 - 36'(us_ff)
                + 36'(cur_ff);
      sat_fv  = snr_pkg::sat36(fv_sum);
      diff    = 36'(bv_ff) - 36'(us_ff);
      sat_diff = snr_pkg::sat36(diff);
      stage_v = snr_pkg::sat36(36'(v_ff) + 36'(prod));
      stage_u = snr_pkg::sat36(36'(u_ff) + 36'(prod));
      nv_sum  = 36'(v_ff) + 36'(prod);
      nu_sum  = 36'(u_ff) + 36'(prod);
      fin_v   = snr_pkg::sat36(nv_sum);
      fin_u   = snr_pkg::sat36(nu_sum);
   end

   // CSR writes
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff      <= 17'd1311;
         sens_ff      <= 17'd13107;
         creset_ff    <= -24'sd4259840;
         jump_ff      <= 21'd524288;
         step_ff      <= 17'd6554;
         rec_after_ff <= 32'd10000;
      end else if (csr.valid) begin
         unique case (csr.index)
            snr_pkg::CsrRate:  rate_ff      <= csr.data[16:0];
            snr_pkg::CsrSens:  sens_ff      <= csr.data[16:0];
            snr_pkg::CsrReset: creset_ff    <= csr.data[23:0];
            snr_pkg::CsrJump:  jump_ff      <= csr.data[20:0];
            snr_pkg::CsrStep:  step_ff      <= csr.data[16:0];
            snr_pkg::CsrRec:   rec_after_ff <= csr.data;
            default: ;
         endcase
      end
   end

   assign req.ready            = (state_ff == ST_IDLE);
   assign rsp.valid            = (state_ff == ST_RESP);
   assign rsp.potential_out    = out_v_ff;
   assign rsp.recovery_out     = out_u_ff;
   assign rsp.spiked           = spk_ff;
   assign rsp.spike_recorded   = rec_ff;
   assign rsp.not_loaded_error = err_ff;

   // sequencer: ISSUE presents operands, WAIT consumes the registered product
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         op_ff     <= OP_SQ;
         stage_ff  <= '0;
         loaded_ff <= 1'b0;
         v_ff      <= '0;
         u_ff      <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  spk_ff <= 1'b0;
                  rec_ff <= 1'b0;
                  err_ff <= 1'b0;
                  cur_ff <= req.input_current;
                  time_ff <= req.sim_time;
                  vs_ff  <= v_ff;
                  us_ff  <= u_ff;
                  sv_ff  <= '0;
                  su_ff  <= '0;
                  stage_ff <= '0;
                  op_ff  <= OP_SQ;
                  if (req.mode) begin
                     v_ff <= req.initial_potential;
                     u_ff <= req.initial_recovery;
                     loaded_ff <= 1'b1;
                     state_ff <= ST_DONE;
                  end else if (!loaded_ff) begin
                     err_ff <= 1'b1;
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_ISSUE;
                  end
               end
            end
            ST_ISSUE: state_ff <= ST_WAIT;
            ST_WAIT: begin
               state_ff <= ST_ISSUE;
               unique case (op_ff)
                  OP_SQ: begin sq_ff <= prod; op_ff <= OP_T; end
                  OP_T:  begin fv_ff <= sat_fv; op_ff <= OP_BV; end
                  OP_BV: begin bv_ff <= prod; op_ff <= OP_FU; end
                  OP_FU: begin fu_ff <= prod; op_ff <= OP_K; end
                  OP_K: begin
                     k_ff <= prod;
                     sv_ff <= (stage_ff == 2'd0 || stage_ff == 2'd3) ?
                        sv_ff + 36'(prod) : sv_ff + 36'(prod) + 36'(prod);
                     op_ff <= OP_L;
                  end
                  OP_L: begin
                     su_ff <= (stage_ff == 2'd0 || stage_ff == 2'd3) ?
                        su_ff + 36'(prod) : su_ff + 36'(prod) + 36'(prod);
                     if (stage_ff == 2'd3) begin
                        op_ff <= OP_SV;
                     end else if (stage_ff == 2'd2) begin
                        // full-step stage: add k3, l3 directly
                        vs_ff <= snr_pkg::sat36(36'(v_ff) + 36'(k_ff));
                        us_ff <= stage_u;
                        stage_ff <= stage_ff + 2'd1;
                        op_ff <= OP_SQ;
                     end else begin
                        // half l is formed on the next pass from the held product
                        op_ff <= OP_HL;
                     end
                  end
                  OP_HL: begin
                     us_ff <= stage_u;
                     op_ff <= OP_HK;
                  end
                  OP_HK: begin
                     vs_ff <= stage_v;
                     stage_ff <= stage_ff + 2'd1;
                     op_ff <= OP_SQ;
                  end
                  OP_SV: begin
                     vs_ff <= fin_v;
                     op_ff <= OP_SU;
                  end
                  OP_SU: begin
                     if (36'(vs_ff) >= snr_pkg::VPeak) begin
                        v_ff <= 32'(creset_ff);
                        u_ff <= snr_pkg::sat36(36'(fin_u) + 36'($signed({1'b0, jump_ff})));
                        spk_ff <= 1'b1;
                        rec_ff <= (time_ff >= rec_after_ff);
                     end else begin
                        v_ff <= vs_ff;
                        u_ff <= fin_u;
                     end
                     state_ff <= ST_DONE;
                  end
                  default: state_ff <= ST_DONE;
               endcase
            end
            ST_DONE: begin
               out_v_ff <= v_ff;
               out_u_ff <= u_ff;
               state_ff <= ST_RESP;
            end
            ST_RESP: if (rsp.ready) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // response only while a request is held
   assert property (@(posedge clock) disable iff (reset) rsp.valid |-> !req.ready)
      else $error("response while idle");
   // an early step never spikes
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.not_loaded_error) |-> !rsp.spiked)
      else $error("error response with spike");
   // recording implies a spike
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.spike_recorded) |-> rsp.spiked)
      else $error("recorded without spike");
endmodule
`default_nettype wire
